/* design/cc20_pkg.sv */
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DFLT = 10;
  localparam int WORDS = 16;
  localparam int KEY_REGS = 4;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_KEY_0_1 = 2'd0;
  localparam logic [1:0] CFG_KEY_2_3 = 2'd1;
  localparam logic [1:0] CFG_KEY_4_5 = 2'd2;
  localparam logic [1:0] CFG_KEY_6_7 = 2'd3;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  typedef logic [WORDS-1:0][31:0] state_t;
  typedef logic [KEY_REGS-1:0][63:0] key_t;
  typedef logic [3:0][31:0] nonce_t;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // starting state: constants, key, then the four request words
  function automatic state_t init_state(key_t key, nonce_t nw);
    state_t s;
    s[0] = SIGMA_0;
    s[1] = SIGMA_1;
    s[2] = SIGMA_2;
    s[3] = SIGMA_3;
    for (int i = 0; i < KEY_REGS; i++) begin
      s[4 + 2 * i] = key[i][31:0];
      s[5 + 2 * i] = key[i][63:32];
    end
    for (int i = 0; i < 4; i++) begin
      s[12 + i] = nw[i];
    end
    return s;
  endfunction

  // one add/xor/rotate step of all four quarter-rounds of a column or
  // diagonal round; step 0..3 picks which line of the quarter-round
  function automatic state_t qr_step(state_t s, logic diag, logic [1:0] step);
    state_t r;
    logic [1:0] q;
    logic [1:0] o1;
    logic [1:0] o2;
    logic [1:0] o3;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    r = s;
    o1 = diag ? 2'd1 : 2'd0;
    o2 = diag ? 2'd2 : 2'd0;
    o3 = diag ? 2'd3 : 2'd0;
    for (int qi = 0; qi < 4; qi++) begin
      q  = 2'(qi);
      ia = {2'b00, q};
      ib = {2'b01, 2'(q + o1)};
      ic = {2'b10, 2'(q + o2)};
      id = {2'b11, 2'(q + o3)};
      case (step)
        2'd0: begin
          r[ia] = s[ia] + s[ib];
          r[id] = rotl(s[id] ^ r[ia], 16);
        end
        2'd1: begin
          r[ic] = s[ic] + s[id];
          r[ib] = rotl(s[ib] ^ r[ic], 12);
        end
        2'd2: begin
          r[ia] = s[ia] + s[ib];
          r[id] = rotl(s[id] ^ r[ia], 8);
        end
        default: begin
          r[ic] = s[ic] + s[id];
          r[ib] = rotl(s[ib] ^ r[ic], 7);
        end
      endcase
    end
    return r;
  endfunction

endpackage

/* design/chacha20_block_function.sv */
// chacha20 / hchacha20 block function, fully pipelined
//
// input channel: in_valid/in_stall with in_func and state words 12..15.
// in_func low gives the chacha20 block (initial state added back), high
// gives hchacha20 (permuted state as is). the key comes from four 64-bit
// registers written through cfg_we/cfg_index/cfg_data; write them only
// while no request is in flight.
// result channel: out_valid/out_stall, all 16 words at once, two per port.
//
// each double round is eight register stages, one add/xor/rotate line of
// the quarter-round per stage across all four quarter-rounds. a request
// passes the entry stage, the round stages and the output register; one
// request is accepted every cycle unless the result side stalls.
// reset clears the key registers and all valid bits.
// a stalled result holds the output register and freezes the whole
// pipeline; in_stall is raised while that lasts, nothing is lost or repeated.
module chacha20_block_function #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_input_word_12,
  input  logic [31:0] in_input_word_13,
  input  logic [31:0] in_input_word_14,
  input  logic [31:0] in_input_word_15,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_words_0_1,
  output logic [63:0] out_words_2_3,
  output logic [63:0] out_words_4_5,
  output logic [63:0] out_words_6_7,
  output logic [63:0] out_words_8_9,
  output logic [63:0] out_words_10_11,
  output logic [63:0] out_words_12_13,
  output logic [63:0] out_words_14_15
);

  localparam int NSTG = 8 * DOUBLE_ROUNDS;

  cc20_pkg::key_t   key_r;
  cc20_pkg::nonce_t in_nw;

  cc20_pkg::state_t st_r  [0:NSTG];
  cc20_pkg::nonce_t nw_r  [0:NSTG];
  logic             fn_r  [0:NSTG];
  logic             vld_r [0:NSTG];

  cc20_pkg::state_t ff_nxt;
  cc20_pkg::state_t out_data_r;
  logic             out_valid_r;
  logic             adv;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign in_nw    = {in_input_word_15, in_input_word_14, in_input_word_13, in_input_word_12};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cc20_pkg::CFG_KEY_0_1: key_r[0] <= cfg_data;
        cc20_pkg::CFG_KEY_2_3: key_r[1] <= cfg_data;
        cc20_pkg::CFG_KEY_4_5: key_r[2] <= cfg_data;
        cc20_pkg::CFG_KEY_6_7: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage builds the starting state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= cc20_pkg::init_state(key_r, in_nw);
      nw_r[0] <= in_nw;
      fn_r[0] <= in_func;
    end
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam logic       DIAG = ((k / 4) % 2) == 1;
    localparam logic [1:0] STEP = 2'(k % 4);

    cc20_pkg::state_t st_nxt;

    assign st_nxt = cc20_pkg::qr_step(st_r[k], DIAG, STEP);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1] <= st_nxt;
        nw_r[k+1] <= nw_r[k];
        fn_r[k+1] <= fn_r[k];
      end
    end
  end

  // feed-forward; the user must keep the key stable while requests are in flight, the block does not enforce it
  always_comb begin
    cc20_pkg::state_t init;
    init = cc20_pkg::init_state(key_r, nw_r[NSTG]);
    for (int i = 0; i < cc20_pkg::WORDS; i++) begin
      ff_nxt[i] = fn_r[NSTG] ? st_r[NSTG][i] : st_r[NSTG][i] + init[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= ff_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_words_0_1   = {out_data_r[1],  out_data_r[0]};
  assign out_words_2_3   = {out_data_r[3],  out_data_r[2]};
  assign out_words_4_5   = {out_data_r[5],  out_data_r[4]};
  assign out_words_6_7   = {out_data_r[7],  out_data_r[6]};
  assign out_words_8_9   = {out_data_r[9],  out_data_r[8]};
  assign out_words_10_11 = {out_data_r[11], out_data_r[10]};
  assign out_words_12_13 = {out_data_r[13], out_data_r[12]};
  assign out_words_14_15 = {out_data_r[15], out_data_r[14]};

endmodule

/* dv/chacha20_block_checker.sv */
module chacha20_block_checker #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_input_word_12,
  input  logic [31:0] in_input_word_13,
  input  logic [31:0] in_input_word_14,
  input  logic [31:0] in_input_word_15,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_words_0_1,
  input  logic [63:0] out_words_2_3,
  input  logic [63:0] out_words_4_5,
  input  logic [63:0] out_words_6_7,
  input  logic [63:0] out_words_8_9,
  input  logic [63:0] out_words_10_11,
  input  logic [63:0] out_words_12_13,
  input  logic [63:0] out_words_14_15,
  output int          errors,
  output int          pending
);

  localparam logic FUNC_HCHACHA = 1'b1;
  localparam int REPORT_LIMIT = 40;

  typedef logic [7:0][63:0] block_t;

  cc20_pkg::key_t key_copy = '0;
  block_t         expected_blocks[$];
  int             fail_count = 0;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic block_t compute_block(logic func, cc20_pkg::nonce_t nw,
                                           cc20_pkg::key_t k);
    cc20_pkg::state_t start;
    cc20_pkg::state_t x;
    block_t blk;
    int a;
    int b;
    int c;
    int d;
    start[0] = cc20_pkg::SIGMA_0;
    start[1] = cc20_pkg::SIGMA_1;
    start[2] = cc20_pkg::SIGMA_2;
    start[3] = cc20_pkg::SIGMA_3;
    for (int i = 0; i < cc20_pkg::KEY_REGS; i++) begin
      start[4 + 2 * i] = k[i][31:0];
      start[5 + 2 * i] = k[i][63:32];
    end
    for (int i = 0; i < 4; i++) begin
      start[12 + i] = nw[i];
    end
    x = start;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // q 0..3 are the column quarter-rounds, 4..7 the diagonal ones
      for (int q = 0; q < 8; q++) begin
        a = q % 4;
        b = 4 + ((q < 4) ? a : (a + 1) % 4);
        c = 8 + ((q < 4) ? a : (a + 2) % 4);
        d = 12 + ((q < 4) ? a : (a + 3) % 4);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 16);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 12);
        x[a] = x[a] + x[b];
        x[d] = rol32(x[d] ^ x[a], 8);
        x[c] = x[c] + x[d];
        x[b] = rol32(x[b] ^ x[c], 7);
      end
    end
    if (func != FUNC_HCHACHA) begin
      for (int i = 0; i < cc20_pkg::WORDS; i++) begin
        x[i] = x[i] + start[i];
      end
    end
    for (int i = 0; i < 8; i++) begin
      blk[i] = {x[2 * i + 1], x[2 * i]};
    end
    return blk;
  endfunction

  always @(posedge clk) begin
    block_t got;
    block_t want;
    cc20_pkg::nonce_t nw;
    if (!rst_n) begin
      key_copy = '0;
      expected_blocks.delete();
    end else begin
      if (in_valid && !in_stall) begin
        nw = {in_input_word_15, in_input_word_14, in_input_word_13, in_input_word_12};
        expected_blocks.push_back(compute_block(in_func, nw, key_copy));
      end
      if (out_valid && !out_stall) begin
        got = {out_words_14_15, out_words_12_13, out_words_10_11, out_words_8_9,
               out_words_6_7, out_words_4_5, out_words_2_3, out_words_0_1};
        if (expected_blocks.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with no request pending, got %h", $time, got);
        end else begin
          want = expected_blocks.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
              fail_count++;
              if (fail_count <= REPORT_LIMIT)
                $display("%0t: out_words_%0d_%0d expected %h got %h",
                         $time, 2 * i, 2 * i + 1, want[i], got[i]);
            end
          end
        end
      end
      if (cfg_we) key_copy[cfg_index] = cfg_data;
    end
    pending <= expected_blocks.size();
    errors <= fail_count;
  end

endmodule

/* dv/tb_chacha20_block_function.sv */
module tb_chacha20_block_function;

  localparam int LATENCY = 8 * cc20_pkg::DOUBLE_ROUNDS_DFLT + 1;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic        func;
    logic [31:0] word12;
    logic [31:0] word13;
    logic [31:0] word14;
    logic [31:0] word15;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [31:0] in_input_word_12 = '0;
  logic [31:0] in_input_word_13 = '0;
  logic [31:0] in_input_word_14 = '0;
  logic [31:0] in_input_word_15 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_words_0_1;
  logic [63:0] out_words_2_3;
  logic [63:0] out_words_4_5;
  logic [63:0] out_words_6_7;
  logic [63:0] out_words_8_9;
  logic [63:0] out_words_10_11;
  logic [63:0] out_words_12_13;
  logic [63:0] out_words_14_15;
  int          errors;
  int          pending;

  logic        hold_req = 1'b0;
  int          burst_left = 0;
  int          stuck_cycles = 0;

  chacha20_block_function DUT (.*);

  chacha20_block_checker u_checker (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("** chacha20_block_function: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side: segments of varying stall density, one long hold-off on request
  initial begin : result_sink
    int seg_len;
    int stall_pct;
    bit held;
    held = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg_len = $urandom_range(1, 64);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 90;
      endcase
      repeat (seg_len) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t random_request();
    request_t rq;
    rq.func = 1'($urandom_range(0, 1));
    rq.word12 = pick_word();
    rq.word13 = pick_word();
    rq.word14 = pick_word();
    rq.word15 = pick_word();
    return rq;
  endfunction

  function automatic cc20_pkg::key_t random_key();
    cc20_pkg::key_t k;
    for (int i = 0; i < cc20_pkg::KEY_REGS; i++) begin
      k[i] = {pick_word(), pick_word()};
    end
    return k;
  endfunction

  // sender works in bursts; a gap follows the end of each burst
  task automatic offer(input request_t rq);
    int gap;
    in_valid <= 1'b1;
    in_func <= rq.func;
    in_input_word_12 <= rq.word12;
    in_input_word_13 <= rq.word13;
    in_input_word_14 <= rq.word14;
    in_input_word_15 <= rq.word15;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                : $urandom_range(0, 20);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_key(input cc20_pkg::key_t k);
    logic [1:0] regs [cc20_pkg::KEY_REGS];
    regs = '{cc20_pkg::CFG_KEY_0_1, cc20_pkg::CFG_KEY_2_3,
             cc20_pkg::CFG_KEY_4_5, cc20_pkg::CFG_KEY_6_7};
    for (int i = 0; i < cc20_pkg::KEY_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= k[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      offer(random_request());
    end
  endtask

  initial begin : stimulus
    logic [31:0] patterns [5];
    request_t rq;
    cc20_pkg::key_t test_key;
    patterns = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001, 32'haaaa_aaaa};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key as left by reset, word extremes in both modes
    for (int p = 0; p < 5; p++) begin
      for (int m = 0; m < 2; m++) begin
        rq.func = 1'(m);
        rq.word12 = patterns[p];
        rq.word13 = patterns[p];
        rq.word14 = (p == 4) ? ~patterns[p] : patterns[p];
        rq.word15 = patterns[p];
        offer(rq);
      end
    end
    drain();

    // all-ones key
    load_key('1);
    for (int m = 0; m < 2; m++) begin
      rq = '0;
      rq.func = 1'(m);
      offer(rq);
    end
    run_random(100);
    drain();

    // byte-sequence key with counter 1 and the classic test nonce
    test_key[0] = {32'h0706_0504, 32'h0302_0100};
    test_key[1] = {32'h0f0e_0d0c, 32'h0b0a_0908};
    test_key[2] = {32'h1716_1514, 32'h1312_1110};
    test_key[3] = {32'h1f1e_1d1c, 32'h1b1a_1918};
    load_key(test_key);
    for (int m = 0; m < 2; m++) begin
      rq.func = 1'(m);
      rq.word12 = 32'h0000_0001;
      rq.word13 = 32'h0900_0000;
      rq.word14 = 32'h4a00_0000;
      rq.word15 = 32'h0000_0000;
      offer(rq);
    end
    run_random(100);
    drain();

    // long hold-off on the result side fills the pipeline
    load_key(random_key());
    hold_req <= 1'b1;
    run_random(200);
    drain();

    load_key('0);
    run_random(100);
    drain();

    for (int ph = 0; ph < 2; ph++) begin
      load_key(random_key());
      run_random(100);
      drain();
    end

    repeat (LATENCY + 16) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("** chacha20_block_function: PASSED **");
    end else begin
      $display("** chacha20_block_function: FAILED **");
    end
    $finish;
  end

endmodule
